>>> design/vntg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vntg_pkg
// shared types, formats and widths of the vertex normal and tangent generator
// ----------------------------------------------------------------------------
package vntg_pkg;

	localparam int VERTEX_COUNT = 1024;
	localparam int IDX_W        = 10;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TRI  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// iterative units
	localparam int SQ_W       = 64;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int DIV_W      = 64;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [IDX_W-1:0]  vertex_index;
		logic [IDX_W-1:0]  second_corner;
		logic [IDX_W-1:0]  third_corner;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   out_vertex;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] tangent_x;
		logic signed [31:0] tangent_y;
		logic signed [31:0] tangent_z;
		logic signed [31:0] bitangent_x;
		logic signed [31:0] bitangent_y;
		logic signed [31:0] bitangent_z;
	} out_item_t;

	// vertex store word: Q8.8 position, Q4.12 uv
	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
	} vtx_t;

	// attribute store word: Q9.14 normal sums, Q16.16 tangent frame
	typedef struct packed {
		logic signed [23:0] sum_x;
		logic signed [23:0] sum_y;
		logic signed [23:0] sum_z;
		logic signed [31:0] tan_x;
		logic signed [31:0] tan_y;
		logic signed [31:0] tan_z;
		logic signed [31:0] bit_x;
		logic signed [31:0] bit_y;
		logic signed [31:0] bit_z;
	} attr_t;

endpackage
`default_nettype wire

>>> design/vntg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vntg_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vntg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/vntg_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vntg_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module vntg_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [vntg_pkg::SQ_W-1:0]   radicand,
	output logic                             done,
	output logic      [vntg_pkg::ROOT_W-1:0] root
);

	localparam int SQ_W  = vntg_pkg::SQ_W;
	localparam int CNT_W = $clog2(vntg_pkg::SQRT_STEPS);

	logic [SQ_W-1:0]  x_q, r_q, b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [SQ_W-1:0]  trial;
	logic             ge;

	assign trial = r_q + b_q;
	assign ge    = x_q >= trial;
	assign done  = done_q;
	assign root  = r_q[vntg_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(vntg_pkg::SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			r_q <= '0;
			b_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

endmodule
`default_nettype wire

>>> design/vntg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vntg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vntg_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [vntg_pkg::DIV_W-1:0] dividend,
	input  wire logic [vntg_pkg::DIV_W-1:0] divisor,
	output logic                            done,
	output logic      [vntg_pkg::DIV_W-1:0] quotient
);

	localparam int DW    = vntg_pkg::DIV_W;
	localparam int CNT_W = $clog2(DW);

	logic [DW-1:0]    rem_q, quo_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DW-1:0]    trial;
	logic             ge;

	// remainder stays below the divisor, so its top bit is never needed
	assign trial    = {rem_q[DW-2:0], quo_q[DW-1]};
	assign ge       = trial >= dvs_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - dvs_q) : trial;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

>>> design/vertex_normal_tangent_gen_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_tangent_gen_unit
// smooth vertex normal and tangent frame generator over a vertex store
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_stall / in_data): one command beat each:
//   load vertex, add triangle or read vertex. out channel (out_valid /
//   out_stall / out_data): one beat for every read vertex command.
//   steps
//   - load: taken while idle, the next beat can follow right away
//   - read: normalization of the stored normal sum: magnitude shifts,
//     squares, a 32-step square root and three 64-step divides in the
//     shared radix-2 divider
//   - add triangle: three vertex store reads, the multiply jobs,
//     normalization, six 64-step tangent divides unless the uv determinant
//     is zero, then three read-modify-write passes over the attribute store
//   in_stall is high whenever a command is in flight; one at a time
//   reset clears the sequencer and the output valid flag only; both stores
//   hold garbage until a vertex is loaded
//   a stalled result sits in the output register while the next command
//   is already taken; a read that finishes before that waits for the slot
// ----------------------------------------------------------------------------
module vertex_normal_tangent_gen_unit #(
	parameter int VERTEX_COUNT = vntg_pkg::VERTEX_COUNT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire vntg_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output vntg_pkg::out_item_t      out_data
);

	localparam int AW    = $clog2(VERTEX_COUNT);
	localparam int IDX_W = vntg_pkg::IDX_W;
	localparam int DW    = vntg_pkg::DIV_W;

	// multiply jobs: three cross terms, determinant, tangent and bitangent numerators
	localparam logic [3:0] JOB_DET  = 4'd3;
	localparam logic [3:0] JOB_TAN0 = 4'd4;
	localparam logic [3:0] JOB_LAST = 4'd9;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_VRD   = 16'h0002,
		S_VCAP  = 16'h0004,
		S_MUL   = 16'h0008,
		S_NSHFT = 16'h0010,
		S_NSQ   = 16'h0020,
		S_SQRT  = 16'h0040,
		S_NDIV  = 16'h0080,
		S_NDIVW = 16'h0100,
		S_NEXT  = 16'h0200,
		S_TDIV  = 16'h0400,
		S_TDIVW = 16'h0800,
		S_WRD   = 16'h1000,
		S_WWR   = 16'h2000,
		S_RCAP  = 16'h4000,
		S_ROUT  = 16'h8000
	} state_t;

	state_t state_q;

	logic [2:0] cnt_q;
	logic [3:0] job_q;
	logic [1:0] mcnt_q;
	logic       tri_q;
	logic       zero_q;
	logic       out_valid_q;

	logic [IDX_W-1:0]      vi_q;
	logic [IDX_W-1:0]      corner_q [3];
	vntg_pkg::vtx_t        vtx_q [3];
	logic signed [35:0]    res_q [10];
	logic signed [65:0]    prod_q, acc_q;
	logic signed [35:0]    vec_q [3];
	logic [35:0]           mag_q [3];
	logic [31:0]           len_q;
	logic signed [15:0]    n_q [3];
	logic signed [31:0]    tb_q [6];
	vntg_pkg::attr_t       attr_q;
	vntg_pkg::out_item_t   out_q;

	// ram ports
	logic                  vtx_we, vtx_re;
	logic [AW-1:0]         vtx_waddr, vtx_raddr;
	vntg_pkg::vtx_t        vtx_wdata, vtx_rdata;
	logic                  attr_we, attr_re;
	logic [AW-1:0]         attr_waddr, attr_raddr;
	vntg_pkg::attr_t       attr_wdata, attr_rdata;

	// iterative units
	logic                  sqrt_start, sqrt_done;
	logic [vntg_pkg::ROOT_W-1:0] sqrt_root;
	logic [vntg_pkg::SQ_W-1:0]   sq_sum;
	logic                  div_start, div_done;
	logic [DW-1:0]         div_dividend, div_divisor, div_quo;

	logic                  in_acc;
	logic                  out_free;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < VERTEX_COUNT;
	endfunction

	function automatic logic [35:0] abs36(input logic signed [35:0] v);
		return v[35] ? 36'(-v) : 36'(v);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [23:0] s,
	                                             input logic signed [15:0] a);
		logic signed [24:0] t;
		t = 25'(s) + 25'(a);
		if (t > 25'sd8388607) begin
			return 24'sh7fffff;
		end else if (t < -25'sd8388608) begin
			return 24'sh800000;
		end
		return t[23:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic [DW-1:0] q, input logic neg);
		if (neg) begin
			return (q[DW-1:31] != '0) ? 32'sh80000000 : -signed'(q[31:0]);
		end
		return (q[DW-1:31] != '0) ? 32'sh7fffffff : signed'(q[31:0]);
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ------------------------------------------------------------------
	// edge vectors and uv deltas from the three captured corners
	// ------------------------------------------------------------------
	logic signed [15:0] pc [3][3];
	logic signed [16:0] ea [3], eb [3], e1 [3], e2 [3];
	logic signed [16:0] du1, dv1, du2, dv2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pc[k][0] = vtx_q[k].pos_x;
			pc[k][1] = vtx_q[k].pos_y;
			pc[k][2] = vtx_q[k].pos_z;
		end
		for (int i = 0; i < 3; i++) begin
			ea[i] = 17'(pc[2][i]) - 17'(pc[1][i]);
			eb[i] = 17'(pc[0][i]) - 17'(pc[1][i]);
			e1[i] = 17'(pc[1][i]) - 17'(pc[0][i]);
			e2[i] = 17'(pc[2][i]) - 17'(pc[0][i]);
		end
		du1 = 17'(vtx_q[1].tex_u) - 17'(vtx_q[0].tex_u);
		dv1 = 17'(vtx_q[1].tex_v) - 17'(vtx_q[0].tex_v);
		du2 = 17'(vtx_q[2].tex_u) - 17'(vtx_q[0].tex_u);
		dv2 = 17'(vtx_q[2].tex_v) - 17'(vtx_q[0].tex_v);
	end

	// each job is x0*y0 - x1*y1
	logic signed [16:0] x0, y0, x1, y1;

	always_comb begin
		x0 = '0;
		y0 = '0;
		x1 = '0;
		y1 = '0;
		case (job_q)
			4'd0: begin x0 = ea[1]; y0 = eb[2]; x1 = ea[2]; y1 = eb[1]; end
			4'd1: begin x0 = ea[2]; y0 = eb[0]; x1 = ea[0]; y1 = eb[2]; end
			4'd2: begin x0 = ea[0]; y0 = eb[1]; x1 = ea[1]; y1 = eb[0]; end
			4'd3: begin x0 = du1; y0 = dv2; x1 = du2; y1 = dv1; end
			4'd4: begin x0 = dv2; y0 = e1[0]; x1 = dv1; y1 = e2[0]; end
			4'd5: begin x0 = dv2; y0 = e1[1]; x1 = dv1; y1 = e2[1]; end
			4'd6: begin x0 = dv2; y0 = e1[2]; x1 = dv1; y1 = e2[2]; end
			4'd7: begin x0 = du1; y0 = e2[0]; x1 = du2; y1 = e1[0]; end
			4'd8: begin x0 = du1; y0 = e2[1]; x1 = du2; y1 = e1[1]; end
			4'd9: begin x0 = du1; y0 = e2[2]; x1 = du2; y1 = e1[2]; end
			default: begin end
		endcase
	end

	// shared multiplier, product registered every cycle
	logic signed [32:0] mul_a, mul_b;
	logic [35:0]        mag_sel;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    mag_sel = mag_q[0];
			2'd1:    mag_sel = mag_q[1];
			2'd2:    mag_sel = mag_q[2];
			default: mag_sel = '0;
		endcase
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_MUL) begin
			mul_a = (mcnt_q == 2'd0) ? 33'(x0) : 33'(x1);
			mul_b = (mcnt_q == 2'd0) ? 33'(y0) : 33'(y1);
		end else if (state_q == S_NSQ) begin
			mul_a = {2'b00, mag_sel[30:0]};
			mul_b = {2'b00, mag_sel[30:0]};
		end
	end

	logic all_zero, too_big;
	logic signed [65:0] acc_sum;

	assign all_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
	assign too_big  = (mag_q[0][35:31] != '0) || (mag_q[1][35:31] != '0)
	               || (mag_q[2][35:31] != '0);
	assign acc_sum  = acc_q + prod_q;
	assign sq_sum   = acc_sum[vntg_pkg::SQ_W-1:0];

	assign sqrt_start = (state_q == S_NSQ) && (cnt_q == 3'd3);

	// divider operands: normal components or tangent numerators
	logic signed [35:0] tnum_sel;
	logic [35:0]        tnum_abs, det_abs;
	logic               tneg;

	assign tnum_sel = res_q[JOB_TAN0 + 4'(cnt_q)];
	assign tnum_abs = abs36(tnum_sel);
	assign det_abs  = abs36(res_q[JOB_DET]);
	assign tneg     = tnum_sel[35] ^ res_q[JOB_DET][35];

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		if (state_q == S_NDIV) begin
			div_start    = 1'b1;
			div_dividend = (DW'(mag_sel[30:0]) << 14) + DW'(len_q >> 1);
			div_divisor  = DW'(len_q);
		end else if (state_q == S_TDIV) begin
			div_start    = 1'b1;
			div_dividend = (DW'(tnum_abs) << 20) + DW'(det_abs >> 1);
			div_divisor  = DW'(det_abs);
		end
	end

	logic signed [15:0] q16;
	assign q16 = signed'(div_quo[15:0]);

	// ------------------------------------------------------------------
	// store ports
	// ------------------------------------------------------------------
	always_comb begin
		vtx_we     = 1'b0;
		vtx_waddr  = AW'(in_data.vertex_index);
		vtx_wdata  = '{pos_x: in_data.pos_x, pos_y: in_data.pos_y, pos_z: in_data.pos_z,
		               tex_u: in_data.tex_u, tex_v: in_data.tex_v};
		vtx_re     = (state_q == S_VRD);
		vtx_raddr  = AW'(corner_q[cnt_q[1:0]]);
		attr_we    = 1'b0;
		attr_waddr = AW'(in_data.vertex_index);
		attr_wdata = '0;
		attr_re    = 1'b0;
		attr_raddr = AW'(corner_q[cnt_q[1:0]]);
		if (in_acc && (in_data.cmd == vntg_pkg::CMD_LOAD)
		    && in_range(in_data.vertex_index)) begin
			vtx_we  = 1'b1;
			attr_we = 1'b1;
		end
		if (in_acc && (in_data.cmd == vntg_pkg::CMD_READ)
		    && in_range(in_data.vertex_index)) begin
			attr_re    = 1'b1;
			attr_raddr = AW'(in_data.vertex_index);
		end
		if (state_q == S_WRD) begin
			attr_re = 1'b1;
		end
		if (state_q == S_WWR) begin
			// accumulate face normal, overwrite tangent frame
			attr_we    = 1'b1;
			attr_waddr = AW'(corner_q[cnt_q[1:0]]);
			attr_wdata.sum_x = sat24(attr_rdata.sum_x, n_q[0]);
			attr_wdata.sum_y = sat24(attr_rdata.sum_y, n_q[1]);
			attr_wdata.sum_z = sat24(attr_rdata.sum_z, n_q[2]);
			attr_wdata.tan_x = tb_q[0];
			attr_wdata.tan_y = tb_q[1];
			attr_wdata.tan_z = tb_q[2];
			attr_wdata.bit_x = tb_q[3];
			attr_wdata.bit_y = tb_q[4];
			attr_wdata.bit_z = tb_q[5];
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			job_q       <= '0;
			mcnt_q      <= '0;
			tri_q       <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_data.cmd)
							vntg_pkg::CMD_TRI: begin
								if (in_range(in_data.vertex_index)
								    && in_range(in_data.second_corner)
								    && in_range(in_data.third_corner)) begin
									cnt_q   <= '0;
									tri_q   <= 1'b1;
									state_q <= S_VRD;
								end
							end
							vntg_pkg::CMD_READ: begin
								tri_q <= 1'b0;
								if (in_range(in_data.vertex_index)) begin
									zero_q  <= 1'b0;
									state_q <= S_RCAP;
								end else begin
									zero_q  <= 1'b1;
									state_q <= S_ROUT;
								end
							end
							default: begin end
						endcase
					end
				end
				S_VRD: state_q <= S_VCAP;
				S_VCAP: begin
					if (cnt_q == 3'd2) begin
						job_q   <= '0;
						mcnt_q  <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_VRD;
					end
				end
				S_MUL: begin
					if (mcnt_q == 2'd2) begin
						mcnt_q <= '0;
						if (job_q == JOB_LAST) begin
							state_q <= S_NSHFT;
						end else begin
							job_q <= job_q + 4'd1;
						end
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				S_NSHFT: begin
					if (all_zero) begin
						state_q <= S_NEXT;
					end else if (!too_big) begin
						cnt_q   <= '0;
						state_q <= S_NSQ;
					end
				end
				S_NSQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						cnt_q   <= '0;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: state_q <= S_NDIVW;
				S_NDIVW: begin
					if (div_done) begin
						if (cnt_q == 3'd2) begin
							state_q <= S_NEXT;
						end else begin
							cnt_q   <= cnt_q + 3'd1;
							state_q <= S_NDIV;
						end
					end
				end
				S_NEXT: begin
					cnt_q <= '0;
					if (!tri_q) begin
						state_q <= S_ROUT;
					end else if (res_q[JOB_DET] == '0) begin
						state_q <= S_WRD;
					end else begin
						state_q <= S_TDIV;
					end
				end
				S_TDIV: state_q <= S_TDIVW;
				S_TDIVW: begin
					if (div_done) begin
						if (cnt_q == 3'd5) begin
							cnt_q   <= '0;
							state_q <= S_WRD;
						end else begin
							cnt_q   <= cnt_q + 3'd1;
							state_q <= S_TDIV;
						end
					end
				end
				S_WRD: state_q <= S_WWR;
				S_WWR: begin
					if (cnt_q == 3'd2) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_WRD;
					end
				end
				S_RCAP: state_q <= S_NSHFT;
				S_ROUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					vi_q        <= in_data.vertex_index;
					corner_q[0] <= in_data.vertex_index;
					corner_q[1] <= in_data.second_corner;
					corner_q[2] <= in_data.third_corner;
				end
			end
			S_VCAP: vtx_q[cnt_q[1:0]] <= vtx_rdata;
			S_MUL: begin
				if (mcnt_q == 2'd1) begin
					acc_q <= prod_q;
				end
				if (mcnt_q == 2'd2) begin
					res_q[job_q] <= acc_q[35:0] - prod_q[35:0];
					if (job_q == JOB_LAST) begin
						for (int i = 0; i < 3; i++) begin
							vec_q[i] <= res_q[i];
							mag_q[i] <= abs36(res_q[i]);
						end
					end
				end
			end
			S_RCAP: begin
				attr_q   <= attr_rdata;
				vec_q[0] <= 36'(attr_rdata.sum_x);
				vec_q[1] <= 36'(attr_rdata.sum_y);
				vec_q[2] <= 36'(attr_rdata.sum_z);
				mag_q[0] <= abs36(36'(attr_rdata.sum_x));
				mag_q[1] <= abs36(36'(attr_rdata.sum_y));
				mag_q[2] <= abs36(36'(attr_rdata.sum_z));
			end
			S_NSHFT: begin
				if (all_zero) begin
					for (int i = 0; i < 3; i++) begin
						n_q[i] <= '0;
					end
				end else if (too_big) begin
					// common right shift until every magnitude is below 2^31
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
			end
			S_NSQ: begin
				if (cnt_q == 3'd1) begin
					acc_q <= prod_q;
				end else if (cnt_q == 3'd2) begin
					acc_q <= acc_sum;
				end
			end
			S_SQRT: begin
				if (sqrt_done) begin
					len_q <= sqrt_root;
				end
			end
			S_NDIVW: begin
				if (div_done) begin
					n_q[cnt_q[1:0]] <= vec_q[cnt_q[1:0]][35] ? -q16 : q16;
				end
			end
			S_NEXT: begin
				if (res_q[JOB_DET] == '0) begin
					for (int i = 0; i < 6; i++) begin
						tb_q[i] <= '0;
					end
				end
			end
			S_TDIVW: begin
				if (div_done) begin
					tb_q[cnt_q] <= sat32(div_quo, tneg);
				end
			end
			S_ROUT: begin
				if (out_free) begin
					out_q.out_vertex <= vi_q;
					if (zero_q) begin
						out_q.normal_x    <= '0;
						out_q.normal_y    <= '0;
						out_q.normal_z    <= '0;
						out_q.tangent_x   <= '0;
						out_q.tangent_y   <= '0;
						out_q.tangent_z   <= '0;
						out_q.bitangent_x <= '0;
						out_q.bitangent_y <= '0;
						out_q.bitangent_z <= '0;
					end else begin
						out_q.normal_x    <= -n_q[0];
						out_q.normal_y    <= -n_q[1];
						out_q.normal_z    <= -n_q[2];
						out_q.tangent_x   <= attr_q.tan_x;
						out_q.tangent_y   <= attr_q.tan_y;
						out_q.tangent_z   <= attr_q.tan_z;
						out_q.bitangent_x <= attr_q.bit_x;
						out_q.bitangent_y <= attr_q.bit_y;
						out_q.bitangent_z <= attr_q.bit_z;
					end
				end
			end
			default: begin end
		endcase
	end

	// ------------------------------------------------------------------
	// stores and iterative units
	// ------------------------------------------------------------------
	vntg_ram #(
		.WIDTH ($bits(vntg_pkg::vtx_t)),
		.DEPTH (VERTEX_COUNT)
	) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (vtx_waddr),
		.wdata (vtx_wdata),
		.re    (vtx_re),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	vntg_ram #(
		.WIDTH ($bits(vntg_pkg::attr_t)),
		.DEPTH (VERTEX_COUNT)
	) u_attr_ram (
		.clk   (clk),
		.we    (attr_we),
		.waddr (attr_waddr),
		.wdata (attr_wdata),
		.re    (attr_re),
		.raddr (attr_raddr),
		.rdata (attr_rdata)
	);

	vntg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_sum),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	vntg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_sqrt_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == S_SQRT))
		else $error("square root finished while nobody waits for it");

	a_div_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_NDIVW) || (state_q == S_TDIVW)))
		else $error("divider finished outside a divide wait");

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WWR) |-> ($past(state_q) == S_WRD))
		else $error("attribute write-back without its read");

	a_rout_free: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ROUT) && out_valid_q && out_stall) |=> (state_q == S_ROUT))
		else $error("read result dropped while output is stalled");

endmodule
`default_nettype wire

>>> verif/vntg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vntg_checker
// Watches both channels of the normal and tangent generator. It keeps its
// own copy of the vertex and attribute stores, predicts every read result
// when a command beat is taken, and compares result beats in order.
// ----------------------------------------------------------------------------
module vntg_checker
	import vntg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_stall,
	input  wire in_item_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_stall,
	input  wire out_item_t out_data,
	output int             errors,
	output int             pending
);

	vtx_t      vtx_mem [VERTEX_COUNT];
	attr_t     attr_mem[VERTEX_COUNT];
	out_item_t read_results[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report(input string field, input longint want, input longint got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
		errors++;
	endtask

	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Q1.14 unit vector, truncating prescale keeps the squares in 64 bits
	function automatic void unit_q14(input longint c0, input longint c1, input longint c2,
			output logic signed [15:0] n0, output logic signed [15:0] n1,
			output logic signed [15:0] n2);
		longint          c[3];
		longint unsigned a[3];
		longint unsigned mx, sq, len, q;
		logic signed [15:0] n[3];
		c[0] = c0; c[1] = c1; c[2] = c2;
		mx = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = mag(c[i]);
			if (a[i] > mx) mx = a[i];
		end
		if (mx == 0) begin
			n0 = 0; n1 = 0; n2 = 0;
			return;
		end
		while (mx >= (64'd1 << 31)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) a[i] >>= 1;
		end
		for (int i = 0; i < 3; i++) sq += a[i] * a[i];
		len = root64(sq);
		for (int i = 0; i < 3; i++) begin
			q = (a[i] * 16384 + len / 2) / len;
			n[i] = (c[i] < 0) ? -16'(q) : 16'(q);
		end
		n0 = n[0]; n1 = n[1]; n2 = n[2];
	endfunction

	// Q16.16 quotient, rounded half away from zero and saturated
	function automatic logic signed [31:0] frame_q16(input longint num, input longint det);
		longint unsigned d, q;
		d = mag(det);
		q = ((mag(num) << 20) + d / 2) / d;
		if ((num < 0) != (det < 0)) begin
			if (q >= 64'h8000_0000) return 32'sh8000_0000;
			return -32'(q);
		end
		if (q > 64'h7fff_ffff) return 32'sh7fff_ffff;
		return 32'(q);
	endfunction

	function automatic logic signed [23:0] sum_sat(input longint s, input longint n);
		longint v;
		v = s + n;
		if (v > 8388607) return 24'sd8388607;
		if (v < -8388608) return -24'sd8388608;
		return 24'(v);
	endfunction

	task automatic add_triangle(input int a, input int b, input int c);
		longint p1[3], p2[3], p3[3], ea[3], eb[3], e1[3], e2[3];
		longint du1, dv1, du2, dv2, det;
		logic signed [15:0] fn[3];
		logic signed [31:0] tg[3], bt[3];
		int corner[3];
		p1 = '{vtx_mem[a].pos_x, vtx_mem[a].pos_y, vtx_mem[a].pos_z};
		p2 = '{vtx_mem[b].pos_x, vtx_mem[b].pos_y, vtx_mem[b].pos_z};
		p3 = '{vtx_mem[c].pos_x, vtx_mem[c].pos_y, vtx_mem[c].pos_z};
		for (int i = 0; i < 3; i++) begin
			ea[i] = p3[i] - p2[i];
			eb[i] = p1[i] - p2[i];
			e1[i] = p2[i] - p1[i];
			e2[i] = p3[i] - p1[i];
		end
		unit_q14(ea[1] * eb[2] - ea[2] * eb[1], ea[2] * eb[0] - ea[0] * eb[2],
			ea[0] * eb[1] - ea[1] * eb[0], fn[0], fn[1], fn[2]);
		du1 = longint'(vtx_mem[b].tex_u) - vtx_mem[a].tex_u;
		dv1 = longint'(vtx_mem[b].tex_v) - vtx_mem[a].tex_v;
		du2 = longint'(vtx_mem[c].tex_u) - vtx_mem[a].tex_u;
		dv2 = longint'(vtx_mem[c].tex_v) - vtx_mem[a].tex_v;
		det = du1 * dv2 - du2 * dv1;
		for (int i = 0; i < 3; i++) begin
			if (det == 0) begin
				tg[i] = 0;
				bt[i] = 0;
			end else begin
				tg[i] = frame_q16(dv2 * e1[i] - dv1 * e2[i], det);
				bt[i] = frame_q16(du1 * e2[i] - du2 * e1[i], det);
			end
		end
		corner = '{a, b, c};
		// a corner named twice gets the face normal twice
		foreach (corner[i]) begin
			attr_mem[corner[i]].sum_x = sum_sat(attr_mem[corner[i]].sum_x, fn[0]);
			attr_mem[corner[i]].sum_y = sum_sat(attr_mem[corner[i]].sum_y, fn[1]);
			attr_mem[corner[i]].sum_z = sum_sat(attr_mem[corner[i]].sum_z, fn[2]);
			attr_mem[corner[i]].tan_x = tg[0];
			attr_mem[corner[i]].tan_y = tg[1];
			attr_mem[corner[i]].tan_z = tg[2];
			attr_mem[corner[i]].bit_x = bt[0];
			attr_mem[corner[i]].bit_y = bt[1];
			attr_mem[corner[i]].bit_z = bt[2];
		end
	endtask

	task automatic take_command(input in_item_t cmd_beat);
		out_item_t r;
		logic signed [15:0] n0, n1, n2;
		int v;
		v = cmd_beat.vertex_index;
		case (cmd_beat.cmd)
			CMD_LOAD: begin
				vtx_mem[v] = '{cmd_beat.pos_x, cmd_beat.pos_y, cmd_beat.pos_z,
					cmd_beat.tex_u, cmd_beat.tex_v};
				attr_mem[v] = '0;
			end
			CMD_TRI: begin
				add_triangle(v, cmd_beat.second_corner, cmd_beat.third_corner);
			end
			CMD_READ: begin
				unit_q14(attr_mem[v].sum_x, attr_mem[v].sum_y, attr_mem[v].sum_z, n0, n1, n2);
				r.out_vertex  = cmd_beat.vertex_index;
				r.normal_x    = -n0;
				r.normal_y    = -n1;
				r.normal_z    = -n2;
				r.tangent_x   = attr_mem[v].tan_x;
				r.tangent_y   = attr_mem[v].tan_y;
				r.tangent_z   = attr_mem[v].tan_z;
				r.bitangent_x = attr_mem[v].bit_x;
				r.bitangent_y = attr_mem[v].bit_y;
				r.bitangent_z = attr_mem[v].bit_z;
				read_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (read_results.size() == 0) begin
			$display("%0t result beat for vertex %0d with nothing outstanding", $realtime,
				got.out_vertex);
			errors++;
			return;
		end
		want = read_results.pop_front();
		if (got.out_vertex !== want.out_vertex)
			report("out_vertex", want.out_vertex, got.out_vertex);
		if (got.normal_x !== want.normal_x) report("normal_x", want.normal_x, got.normal_x);
		if (got.normal_y !== want.normal_y) report("normal_y", want.normal_y, got.normal_y);
		if (got.normal_z !== want.normal_z) report("normal_z", want.normal_z, got.normal_z);
		if (got.tangent_x !== want.tangent_x)
			report("tangent_x", want.tangent_x, got.tangent_x);
		if (got.tangent_y !== want.tangent_y)
			report("tangent_y", want.tangent_y, got.tangent_y);
		if (got.tangent_z !== want.tangent_z)
			report("tangent_z", want.tangent_z, got.tangent_z);
		if (got.bitangent_x !== want.bitangent_x)
			report("bitangent_x", want.bitangent_x, got.bitangent_x);
		if (got.bitangent_y !== want.bitangent_y)
			report("bitangent_y", want.bitangent_y, got.bitangent_y);
		if (got.bitangent_z !== want.bitangent_z)
			report("bitangent_z", want.bitangent_z, got.bitangent_z);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall === 1'b0) check_result(out_data);
			if (in_valid === 1'b1 && in_stall === 1'b0) take_command(in_data);
			pending = read_results.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load, triangle, read and unknown commands into the normal and
// tangent generator with random gaps and result stalls; the checker beside
// the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import vntg_pkg::*;

	localparam int RANDOM_BEATS = 1800;
	localparam int POOL         = 48;   // hot vertices so normal sums pile up
	localparam int DRAIN_CYCLES = 1500; // longer than one triangle

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	int        errors;
	int        pending;

	bit        loaded[VERTEX_COUNT];
	int        loaded_list[$];
	bit        quiet;   // stretch with no gaps and no stalls

	vertex_normal_tangent_gen_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	vntg_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		if (quiet) return 0;
		roll = $urandom_range(99);
		if (roll < 50) return 0;
		if (roll < 90) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// result side backpressure
	initial begin
		int left;
		out_stall = 1'b0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left > 0) begin
				left--;
				out_stall <= 1'b1;
			end else begin
				left = pick_gap();
				out_stall <= (left > 0);
				if (left > 0) left--;
			end
		end
	end

	function automatic in_item_t make_beat(input logic [1:0] cmd, input int a, input int b,
			input int c, input int px, input int py, input int pz, input int u, input int v);
		in_item_t it;
		it.cmd           = cmd;
		it.vertex_index  = a;
		it.second_corner = b;
		it.third_corner  = c;
		it.pos_x         = px;
		it.pos_y         = py;
		it.pos_z         = pz;
		it.tex_u         = u;
		it.tex_v         = v;
		return it;
	endfunction

	// one beat: optional gap, then hold valid and payload until taken
	task automatic send(input in_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (it.cmd == CMD_LOAD && !loaded[it.vertex_index]) begin
			loaded[it.vertex_index] = 1'b1;
			loaded_list.push_back(it.vertex_index);
		end
	endtask

	function automatic int any_loaded();
		if ($urandom_range(3) != 0) begin
			// prefer the hot pool when it has entries
			for (int tries = 0; tries < 8; tries++) begin
				int k;
				k = $urandom_range(POOL - 1);
				if (loaded[k]) return k;
			end
		end
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	function automatic int coord(input bit narrow);
		if (narrow) return $signed($urandom_range(1024)) - 512;
		return $signed(16'($urandom));
	endfunction

	function automatic in_item_t random_beat();
		int roll, a;
		bit narrow;
		in_item_t it;
		roll   = $urandom_range(99);
		narrow = ($urandom_range(1) == 0);
		it = make_beat(CMD_LOAD, 0, $urandom, $urandom, coord(narrow), coord(narrow),
			coord(narrow), coord(narrow), coord(narrow));
		if (roll < 33) begin
			a = ($urandom_range(3) == 0) ? $urandom_range(VERTEX_COUNT - 1)
				: $urandom_range(POOL - 1);
			it.vertex_index = a;
		end else if (roll < 70) begin
			it.cmd           = CMD_TRI;
			it.vertex_index  = any_loaded();
			it.second_corner = any_loaded();
			it.third_corner  = any_loaded();
		end else if (roll < 96) begin
			it.cmd          = CMD_READ;
			it.vertex_index = any_loaded();
		end else begin
			// unknown command, zero vertex index, the lower 96 bits random
			it = in_item_t'({$urandom, $urandom, $urandom});
			it.cmd = 2'd3;
		end
		return it;
	endfunction

	initial begin
		in_valid = 1'b0;
		in_data  = '0;
		quiet    = 1'b0;
		arst_n   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// unit triangle in the xy plane
		send(make_beat(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_beat(CMD_LOAD, 1, 0, 0, 256, 0, 0, 4096, 0));
		send(make_beat(CMD_LOAD, 2, 0, 0, 0, 256, 0, 0, 4096));
		// zero normal sum right after a load
		send(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_beat(CMD_TRI, 0, 1, 2, 0, 0, 0, 0, 0));
		send(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_beat(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0));
		// extreme positions over a uv step of one lsb: tangent saturates
		send(make_beat(CMD_LOAD, 3, 0, 0, -32768, -32768, -32768, 0, 0));
		send(make_beat(CMD_LOAD, 4, 0, 0, 32767, 32767, 32767, 1, 0));
		send(make_beat(CMD_LOAD, 5, 0, 0, 32767, -32768, 0, 0, 1));
		send(make_beat(CMD_TRI, 3, 4, 5, 0, 0, 0, 0, 0));
		send(make_beat(CMD_READ, 3, 0, 0, 0, 0, 0, 0, 0));
		// collinear corners: zero face normal, extreme uvs
		send(make_beat(CMD_LOAD, 1023, 0, 0, 512, 512, 512, -32768, 32767));
		send(make_beat(CMD_TRI, 0, 4, 1023, 0, 0, 0, 0, 0));
		send(make_beat(CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 0));
		// repeated corner
		send(make_beat(CMD_TRI, 0, 0, 1, 0, 0, 0, 0, 0));
		send(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		// same uv at two corners: zero determinant
		send(make_beat(CMD_LOAD, 7, 0, 0, 0, 0, 512, 4096, 0));
		send(make_beat(CMD_TRI, 0, 1, 7, 0, 0, 0, 0, 0));
		send(make_beat(CMD_READ, 7, 0, 0, 0, 0, 0, 0, 0));
		// unknown command with every bit set
		send(in_item_t'('1));
		send(make_beat(CMD_READ, 4, 0, 0, 0, 0, 0, 0, 0));

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 150 == 0) quiet = ($urandom_range(3) == 0);
			send(random_beat());
		end
		@(negedge clk);
		in_valid <= 1'b0;
		quiet = 1'b1;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/vntg_pkg.sv
design/vntg_ram.sv
design/vntg_sqrt.sv
design/vntg_div.sv
design/vertex_normal_tangent_gen_unit.sv
verif/vntg_checker.sv
verif/tb_top.sv
